// ===== rtl/brfd_pkg.sv =====
// ----------------------------------------------------------------------------
// brfd_pkg
// Types and constants shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brfd_pkg;

    localparam int KIND_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 7;
    localparam int HELD_W    = 9;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [REQ_W-1:0] BURST_MAX = 7'd64;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BURST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_OUT  = 2'd2
    } brfd_state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
    } brfd_cmd_t;

    typedef struct packed {
        logic more;
    } brfd_sts_t;

endpackage

// ===== rtl/brfd_ram.sv =====
// ----------------------------------------------------------------------------
// brfd_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/brfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// brfd_ctrl
// Sequencer for the byte ring FIFO: takes an item, loads a result, holds it
// until taken, and steps through the bytes of a burst pop.
// ----------------------------------------------------------------------------
module brfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output brfd_pkg::brfd_cmd_t cmd,
    input  brfd_pkg::brfd_sts_t sts
);
    import brfd_pkg::*;

    brfd_state_t state_reg;
    brfd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                m_valid = 1'b1;
                if (m_ready)
                begin
                    if (sts.more)
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/brfd_dp.sv =====
// ----------------------------------------------------------------------------
// brfd_dp
// Datapath of the byte ring FIFO: head and tail pointers, the byte store,
// the burst counter and the result register.
// ----------------------------------------------------------------------------
module brfd_dp #(
    parameter int DEPTH = 512
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  brfd_pkg::brfd_cmd_t                   cmd,
    output brfd_pkg::brfd_sts_t                   sts,
    input  logic [brfd_pkg::KIND_W-1:0]           kind,
    input  logic [brfd_pkg::BYTE_W-1:0]           data_byte,
    input  logic [brfd_pkg::REQ_W-1:0]            request_count,
    output logic [brfd_pkg::BYTE_W-1:0]           out_byte,
    output logic                                  out_valid,
    output logic [brfd_pkg::HELD_W-1:0]           held_count,
    output logic                                  dropped,
    output logic                                  last
);
    import brfd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [REQ_W-1:0]  remain_reg, remain_next;
    logic              burst_reg, burst_next;
    logic              valid_reg, valid_next;
    logic              drop_reg, drop_next;

    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_valid_reg;
    logic [HELD_W-1:0] held_count_reg;
    logic              dropped_reg;
    logic              last_reg;

    logic [PW-1:0]     head_inc, tail_inc;
    logic [CW-1:0]     held;
    logic [31:0]       held_w;
    logic              empty, full;
    logic [REQ_W-1:0]  cap, burst_n;
    logic              we;
    logic [BYTE_W-1:0] rdata;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PW'(1);
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + PW'(1);
    assign held     = (tail_reg >= head_reg) ? CW'(tail_reg) - CW'(head_reg)
                                             : CW'(tail_reg) + DEPTH_C - CW'(head_reg);
    assign held_w   = 32'(held);
    assign empty    = (head_reg == tail_reg);
    assign full     = (tail_inc == head_reg);
    assign cap      = (request_count > BURST_MAX) ? BURST_MAX : request_count;
    assign burst_n  = (held_w < 32'(cap)) ? held_w[REQ_W-1:0] : cap;
    assign we       = cmd.accept && (kind == KIND_PUSH) && !full;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        remain_next = remain_reg;
        burst_next  = burst_reg;
        valid_next  = valid_reg;
        drop_next   = drop_reg;
        if (cmd.accept)
        begin
            burst_next  = 1'b0;
            valid_next  = 1'b0;
            drop_next   = 1'b0;
            remain_next = '0;
            case (kind)
                KIND_PUSH:
                begin
                    drop_next = full;
                    if (!full)
                    begin
                        tail_next = tail_inc;
                    end
                end
                KIND_POP:
                begin
                    valid_next = !empty;
                    if (!empty)
                    begin
                        head_next = head_inc;
                    end
                end
                KIND_PEEK:
                begin
                    valid_next = !empty;
                end
                KIND_BURST:
                begin
                    if (burst_n != '0)
                    begin
                        burst_next  = 1'b1;
                        valid_next  = 1'b1;
                        remain_next = burst_n;
                        head_next   = head_inc;
                    end
                end
                KIND_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.step)
        begin
            remain_next = remain_reg - REQ_W'(1);
            head_next   = head_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            remain_reg <= '0;
            burst_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            remain_reg <= remain_next;
            burst_reg  <= burst_next;
            valid_reg  <= valid_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg   <= valid_reg ? rdata : '0;
            out_valid_reg  <= valid_reg;
            held_count_reg <= held_w[HELD_W-1:0];
            dropped_reg    <= drop_reg;
            last_reg       <= !(burst_reg && (remain_reg > REQ_W'(1)));
        end
    end

    brfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (tail_reg),
        .wdata (data_byte),
        .raddr (head_reg),
        .rdata (rdata)
    );

    assign sts.more   = burst_reg && (remain_reg > REQ_W'(1));
    assign out_byte   = out_byte_reg;
    assign out_valid  = out_valid_reg;
    assign held_count = held_count_reg;
    assign dropped    = dropped_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/byte_ring_fifo_drop_on_full.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_drop_on_full
// Byte FIFO kept as a circular buffer that drops pushes when full.
// ----------------------------------------------------------------------------
// An accepted item passes through the load state, where the result register is
// loaded, and its result is then offered until taken. No new item is accepted
// until the result is taken; each further byte of a burst pop passes through the
// load state again, because of the registered read of the byte store and the
// single result register.
// Reset clears both pointers and the sequencer; the store is not cleared.
module byte_ring_fifo_drop_on_full #(
    parameter int DEPTH = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // data_byte [7:0], request_count [14:8], zero [15].
    input  logic [brfd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // kind [2:0].
    input  logic [brfd_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_byte [7:0], out_valid [8], held_count [17:9], dropped [18], zero [23:19].
    output logic [brfd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);
    import brfd_pkg::*;

    brfd_cmd_t         cmd;
    brfd_sts_t         sts;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic [HELD_W-1:0] held_count;
    logic              dropped;

    brfd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    brfd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (s_axis_tuser),
        .data_byte     (s_axis_tdata[7:0]),
        .request_count (s_axis_tdata[14:8]),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .held_count    (held_count),
        .dropped       (dropped),
        .last          (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, dropped, held_count, out_valid, out_byte};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output handshakes are both open");

    a_drop_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(dropped && out_valid))
        else $error("a dropped push carries a byte");

    a_burst_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> out_valid)
        else $error("a non-final result of an item carries no byte");

    a_step_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (cmd.load && !m_axis_tvalid))
        else $error("a burst step did not reload the result register");

endmodule
